@@ src/vbss_pkg.sv @@
// ============================================================================
// vbss_pkg
// Shared types, constants and the varicode ROM for the BPSK symbol source.
// ============================================================================
package vbss_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 256;

  localparam logic [7:0] IDLE_CODE  = 8'h01;
  localparam logic [7:0] ESC_CODE   = 8'h1B;
  localparam logic [7:0] MACRO_CODE = 8'h08;
  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] PRINT_MIN  = 8'd32;
  localparam logic [7:0] PRINT_MAX  = 8'd122;

  typedef enum logic {
    ITEM_ENQ  = 1'b0,
    ITEM_TICK = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic [7:0] ch;
  } item_t;

  // Command from the serializer to the character queue.
  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic [1:0] pop;
  } q_cmd_t;

  // Status of the character queue; head0 and head1 are the two oldest bytes.
  typedef struct packed {
    logic       empty;
    logic       multi;
    logic       full;
    logic [7:0] head0;
    logic [7:0] head1;
  } q_stat_t;

  // Varicode words, left-aligned in 16 bits. Codes above 127 have no word.
  function automatic logic [15:0] vc_word(input logic [7:0] ch);
    logic [15:0] w;
    case (ch)
      8'd0:   w = 16'b10101010_11000000;
      8'd1:   w = 16'b10110110_11000000;
      8'd2:   w = 16'b10111011_01000000;
      8'd3:   w = 16'b11011101_11000000;
      8'd4:   w = 16'b10111010_11000000;
      8'd5:   w = 16'b11010111_11000000;
      8'd6:   w = 16'b10111011_11000000;
      8'd7:   w = 16'b10111111_01000000;
      8'd8:   w = 16'b10111111_11000000;
      8'd9:   w = 16'b11101111_00000000;
      8'd10:  w = 16'b11101000_00000000;
      8'd11:  w = 16'b11011011_11000000;
      8'd12:  w = 16'b10110111_01000000;
      8'd13:  w = 16'b11111000_00000000;
      8'd14:  w = 16'b11011101_01000000;
      8'd15:  w = 16'b11101010_11000000;
      8'd16:  w = 16'b10111101_11000000;
      8'd17:  w = 16'b10111101_01000000;
      8'd18:  w = 16'b11101011_01000000;
      8'd19:  w = 16'b11101011_11000000;
      8'd20:  w = 16'b11010110_11000000;
      8'd21:  w = 16'b11011010_11000000;
      8'd22:  w = 16'b11011011_01000000;
      8'd23:  w = 16'b11010101_11000000;
      8'd24:  w = 16'b11011110_11000000;
      8'd25:  w = 16'b11011111_01000000;
      8'd26:  w = 16'b11101101_11000000;
      8'd27:  w = 16'b11010101_01000000;
      8'd28:  w = 16'b11010111_01000000;
      8'd29:  w = 16'b11101110_11000000;
      8'd30:  w = 16'b10111110_11000000;
      8'd31:  w = 16'b11011111_11000000;
      8'd32:  w = 16'b10000000_00000000;
      8'd33:  w = 16'b11111111_10000000;
      8'd34:  w = 16'b10101111_10000000;
      8'd35:  w = 16'b11111010_10000000;
      8'd36:  w = 16'b11101101_10000000;
      8'd37:  w = 16'b10110101_01000000;
      8'd38:  w = 16'b10101110_11000000;
      8'd39:  w = 16'b10111111_10000000;
      8'd40:  w = 16'b11111011_00000000;
      8'd41:  w = 16'b11110111_00000000;
      8'd42:  w = 16'b10110111_10000000;
      8'd43:  w = 16'b11101111_10000000;
      8'd44:  w = 16'b11101010_00000000;
      8'd45:  w = 16'b11010100_00000000;
      8'd46:  w = 16'b10101110_00000000;
      8'd47:  w = 16'b11010111_10000000;
      8'd48:  w = 16'b10110111_00000000;
      8'd49:  w = 16'b10111101_00000000;
      8'd50:  w = 16'b11101101_00000000;
      8'd51:  w = 16'b11111111_00000000;
      8'd52:  w = 16'b10111011_10000000;
      8'd53:  w = 16'b10101101_10000000;
      8'd54:  w = 16'b10110101_10000000;
      8'd55:  w = 16'b11010110_10000000;
      8'd56:  w = 16'b11010101_10000000;
      8'd57:  w = 16'b11011011_10000000;
      8'd58:  w = 16'b11110101_00000000;
      8'd59:  w = 16'b11011110_10000000;
      8'd60:  w = 16'b11110110_10000000;
      8'd61:  w = 16'b10101010_00000000;
      8'd62:  w = 16'b11101011_10000000;
      8'd63:  w = 16'b10101011_11000000;
      8'd64:  w = 16'b10101111_01000000;
      8'd65:  w = 16'b11111010_00000000;
      8'd66:  w = 16'b11101011_00000000;
      8'd67:  w = 16'b10101101_00000000;
      8'd68:  w = 16'b10110101_00000000;
      8'd69:  w = 16'b11101110_00000000;
      8'd70:  w = 16'b11011011_00000000;
      8'd71:  w = 16'b11111101_00000000;
      8'd72:  w = 16'b10101010_10000000;
      8'd73:  w = 16'b11111110_00000000;
      8'd74:  w = 16'b11111110_10000000;
      8'd75:  w = 16'b10111110_10000000;
      8'd76:  w = 16'b11010111_00000000;
      8'd77:  w = 16'b10111011_00000000;
      8'd78:  w = 16'b11011101_00000000;
      8'd79:  w = 16'b10101011_00000000;
      8'd80:  w = 16'b11010101_00000000;
      8'd81:  w = 16'b11101110_10000000;
      8'd82:  w = 16'b10101111_00000000;
      8'd83:  w = 16'b11011110_00000000;
      8'd84:  w = 16'b11011010_00000000;
      8'd85:  w = 16'b10101011_10000000;
      8'd86:  w = 16'b11011010_10000000;
      8'd87:  w = 16'b10101110_10000000;
      8'd88:  w = 16'b10111010_10000000;
      8'd89:  w = 16'b10111101_10000000;
      8'd90:  w = 16'b10101011_01000000;
      8'd91:  w = 16'b11111011_10000000;
      8'd92:  w = 16'b11110111_10000000;
      8'd93:  w = 16'b11111101_10000000;
      8'd94:  w = 16'b10101111_11000000;
      8'd95:  w = 16'b10110110_10000000;
      8'd96:  w = 16'b10110111_11000000;
      8'd97:  w = 16'b10110000_00000000;
      8'd98:  w = 16'b10111110_00000000;
      8'd99:  w = 16'b10111100_00000000;
      8'd100: w = 16'b10110100_00000000;
      8'd101: w = 16'b11000000_00000000;
      8'd102: w = 16'b11110100_00000000;
      8'd103: w = 16'b10110110_00000000;
      8'd104: w = 16'b10101100_00000000;
      8'd105: w = 16'b11010000_00000000;
      8'd106: w = 16'b11110101_10000000;
      8'd107: w = 16'b10111111_00000000;
      8'd108: w = 16'b11011000_00000000;
      8'd109: w = 16'b11101100_00000000;
      8'd110: w = 16'b11110000_00000000;
      8'd111: w = 16'b11100000_00000000;
      8'd112: w = 16'b11111100_00000000;
      8'd113: w = 16'b11011111_10000000;
      8'd114: w = 16'b10101000_00000000;
      8'd115: w = 16'b10111000_00000000;
      8'd116: w = 16'b10100000_00000000;
      8'd117: w = 16'b11011100_00000000;
      8'd118: w = 16'b11110110_00000000;
      8'd119: w = 16'b11010110_00000000;
      8'd120: w = 16'b11011111_00000000;
      8'd121: w = 16'b10111010_00000000;
      8'd122: w = 16'b11101010_10000000;
      8'd123: w = 16'b10101101_11000000;
      8'd124: w = 16'b11011101_10000000;
      8'd125: w = 16'b10101101_01000000;
      8'd126: w = 16'b10110101_11000000;
      8'd127: w = 16'b11101101_01000000;
      default: w = 16'h0000;
    endcase
    return w;
  endfunction

endpackage

@@ src/varicode_bpsk_symbol_source.sv @@
// ============================================================================
// varicode_bpsk_symbol_source
// PSK31 varicode symbol source with a character queue.
// ============================================================================
// Usage:
//   Command channel (cmd_valid/cmd_ready, mode, char_in): mode 0 enqueues
//   char_in, mode 1 is a symbol tick. Each item gives exactly one result on
//   the result channel (res_valid/res_ready): accepted for an enqueue,
//   phase_reverse, echo_valid/echo_char and macro_pulse for a tick.
//   An item is registered in the item queue, then its result in the result
//   register. One item per cycle is sustained: a two-entry item queue feeds
//   the serializer, which executes each item against the character store;
//   the store reads its two head bytes ahead into registers with write
//   forwarding. If the receiver stalls, the result register holds, the item
//   queue fills and cmd_ready falls after two further items.
//   Reset (rst, synchronous) empties the character queue and the item queue,
//   clears the shifter and leaves a closing zero pending, so the first tick
//   sends a reversal. Stored bytes are not cleared; none is needed.
// ============================================================================
module varicode_bpsk_symbol_source #(
  parameter int QUEUE_DEPTH = vbss_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  logic       mode,
  input  logic [7:0] char_in,
  output logic       res_valid,
  input  logic       res_ready,
  output logic       accepted,
  output logic       phase_reverse,
  output logic       echo_valid,
  output logic [7:0] echo_char,
  output logic       macro_pulse
);
  import vbss_pkg::*;

  logic    item_valid;
  logic    item_ready;
  item_t   item;
  q_cmd_t  qcmd;
  q_stat_t qstat;

  vbss_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .mode       (mode),
    .char_in    (char_in),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  vbss_char_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_char_queue (
    .clk  (clk),
    .rst  (rst),
    .cmd  (qcmd),
    .stat (qstat)
  );

  vbss_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .qcmd          (qcmd),
    .qstat         (qstat),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .accepted      (accepted),
    .phase_reverse (phase_reverse),
    .echo_valid    (echo_valid),
    .echo_char     (echo_char),
    .macro_pulse   (macro_pulse)
  );

endmodule

@@ src/vbss_front.sv @@
// ============================================================================
// vbss_front
// Accepts items, classifies them as enqueue or tick, and holds them in a
// two-entry queue until the serializer takes them.
// ============================================================================
module vbss_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  logic             mode,
  input  logic [7:0]       char_in,
  output logic             item_valid,
  input  logic             item_ready,
  output vbss_pkg::item_t  item
);
  import vbss_pkg::*;

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;
  item_t      item_in;

  always_comb begin
    item_in.kind = mode ? ITEM_TICK : ITEM_ENQ;
    // A tick carries no character.
    item_in.ch   = mode ? 8'h00 : char_in;
  end

  assign cmd_ready  = (cnt != 2'd2);
  assign item_valid = (cnt != 2'd0);
  assign item       = slot[rd_ptr];
  assign push       = cmd_valid && cmd_ready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // The pointers differ exactly when one item is held.
  assert property (@(posedge clk) disable iff (rst) (cnt == 2'd1) == (wr_ptr != rd_ptr))
    else $error("vbss_front: item queue pointers out of step with count");

endmodule

@@ src/vbss_char_queue.sv @@
// ============================================================================
// vbss_char_queue
// Circular character store with head, tail and fill count. The two oldest
// bytes are read ahead into registers so that a fetch sees them at once.
// ============================================================================
module vbss_char_queue #(
  parameter int QUEUE_DEPTH = vbss_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  vbss_pkg::q_cmd_t  cmd,
  output vbss_pkg::q_stat_t stat
);
  import vbss_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  logic [7:0]    mem [QUEUE_DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] count;
  logic [7:0]    rd0;
  logic [7:0]    rd1;
  logic [AW-1:0] head_next;
  logic [AW-1:0] tail_next;
  logic [AW-1:0] rd_addr1;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] i);
    logic [AW:0] r;
    r = (i >= DEPTH_W) ? (i - DEPTH_W) : i;
    return r[AW-1:0];
  endfunction

  assign head_next = wrap({1'b0, head} + (AW + 1)'(cmd.pop));
  assign tail_next = cmd.push ? wrap({1'b0, tail} + (AW + 1)'(1)) : tail;
  assign rd_addr1  = wrap({1'b0, head_next} + (AW + 1)'(1));

  // Reads follow the next head; a byte written this cycle to a read address
  // is forwarded so that a fresh enqueue is visible on the next item.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= cmd.data;
    end
    rd0 <= (cmd.push && (tail == head_next)) ? cmd.data : mem[head_next];
    rd1 <= (cmd.push && (tail == rd_addr1))  ? cmd.data : mem[rd_addr1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count + CW'(cmd.push) - CW'(cmd.pop);
    end
  end

  always_comb begin
    stat.empty = (count == '0);
    stat.multi = (count > CW'(1));
    stat.full  = (count == DEPTH_C);
    stat.head0 = rd0;
    stat.head1 = rd1;
  end

  assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("vbss_char_queue: fill count above depth");

  assert property (@(posedge clk) disable iff (rst)
                   (cmd.pop != 2'd0) |-> (count >= CW'(cmd.pop)))
    else $error("vbss_char_queue: more bytes removed than held");

  assert property (@(posedge clk) disable iff (rst) cmd.push |-> !stat.full)
    else $error("vbss_char_queue: byte stored into a full queue");

endmodule

@@ src/vbss_back.sv @@
// ============================================================================
// vbss_back
// Carries out one item per cycle while results are taken: stores characters,
// or makes the next BPSK symbol from the varicode shifter; registers the result.
// ============================================================================
module vbss_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  vbss_pkg::item_t   item,
  output vbss_pkg::q_cmd_t  qcmd,
  input  vbss_pkg::q_stat_t qstat,
  output logic              res_valid,
  input  logic              res_ready,
  output logic              accepted,
  output logic              phase_reverse,
  output logic              echo_valid,
  output logic [7:0]        echo_char,
  output logic              macro_pulse
);
  import vbss_pkg::*;

  logic [15:0] code_shift;
  logic [15:0] code_shift_next;
  logic        ending_zero_due;
  logic        ending_zero_due_next;
  logic        fire;
  logic        acc;
  logic        rev;
  logic        ev;
  logic [7:0]  ec;
  logic        mac;
  logic [7:0]  ch;
  logic [1:0]  pop;
  logic        push;

  assign item_ready = !res_valid || res_ready;
  assign fire       = item_valid && item_ready;

  always_comb begin
    acc                  = 1'b0;
    rev                  = 1'b0;
    ev                   = 1'b0;
    ec                   = 8'h00;
    mac                  = 1'b0;
    ch                   = IDLE_CODE;
    pop                  = 2'd0;
    push                 = 1'b0;
    code_shift_next      = code_shift;
    ending_zero_due_next = ending_zero_due;
    case (item.kind)
      ITEM_ENQ: begin
        if (!qstat.full) begin
          acc  = 1'b1;
          push = 1'b1;
        end
      end
      ITEM_TICK: begin
        if (code_shift == 16'h0000) begin
          rev = 1'b1;
          if (ending_zero_due) begin
            ending_zero_due_next = 1'b0;
          end else begin
            // Fetch: an escape waits at the head unless the macro byte follows.
            if (qstat.empty) begin
              ch = IDLE_CODE;
            end else if (qstat.head0 != ESC_CODE) begin
              ch  = qstat.head0;
              pop = 2'd1;
            end else if (qstat.multi && (qstat.head1 == MACRO_CODE)) begin
              ch  = IDLE_CODE;
              pop = 2'd2;
              mac = 1'b1;
            end else begin
              ch = SPACE_CODE;
            end
            if ((ch >= PRINT_MIN) && (ch <= PRINT_MAX)) begin
              ev = 1'b1;
              ec = ch;
            end
            if (ch != IDLE_CODE) begin
              code_shift_next = vc_word(ch);
            end
          end
        end else begin
          rev             = !code_shift[15];
          code_shift_next = {code_shift[14:0], 1'b0};
          if (code_shift[14:0] == 15'h0000) begin
            ending_zero_due_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    qcmd.push = fire && push;
    qcmd.data = item.ch;
    qcmd.pop  = fire ? pop : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_shift      <= 16'h0000;
      ending_zero_due <= 1'b1;
      res_valid       <= 1'b0;
    end else begin
      if (fire) begin
        code_shift      <= code_shift_next;
        ending_zero_due <= ending_zero_due_next;
        res_valid       <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      accepted      <= acc;
      phase_reverse <= rev;
      echo_valid    <= ev;
      echo_char     <= ec;
      macro_pulse   <= mac;
    end
  end

  // While a word is being shifted out, its closing zero cannot be pending yet.
  assert property (@(posedge clk) disable iff (rst)
                   (code_shift != 16'h0000) |-> !ending_zero_due)
    else $error("vbss_back: closing zero pending during a word");

  assert property (@(posedge clk) disable iff (rst)
                   (res_valid && macro_pulse) |-> (phase_reverse && !echo_valid))
    else $error("vbss_back: macro item without idle reversal");

  assert property (@(posedge clk) disable iff (rst)
                   (res_valid && accepted) |-> (!phase_reverse && !echo_valid))
    else $error("vbss_back: enqueue result carries symbol fields");

endmodule
